// ----- hw/rtl/urrm_pkg.sv -----
// Shared types and constants for the unbiased random range mapper.
`timescale 1ns / 1ps

package urrm_pkg;

  localparam int unsigned WORD_BITS         = 32;
  localparam int unsigned FRACTION_BITS     = 24;
  localparam int unsigned STATUS_BITS       = 3;
  localparam int unsigned MODE_BITS         = 2;
  localparam int unsigned CFG_IDX_BITS      = 2;
  localparam int unsigned ATTEMPT_LIMIT_DEF = 16;
  localparam int unsigned DIV_CNT_BITS      = $clog2(WORD_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_RANGE = 2'd0,
    MODE_BOOL  = 2'd1,
    MODE_FRAC  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_REJECT    = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_BAD_RANGE = 3'd3,
    ST_FAULT     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/urrm_ctrl.sv -----
// Controller state machine sequencing load, remainder iterations and result write.
`timescale 1ns / 1ps

module urrm_ctrl
  import urrm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = status_i.needs_div ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/urrm_dpath.sv -----
// Datapath: configuration, restoring remainder unit, result select and output register.
`timescale 1ns / 1ps

module urrm_dpath
  import urrm_pkg::*;
#(
  parameter int unsigned AttemptLimit = ATTEMPT_LIMIT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  input  logic [WORD_BITS-1:0]    in_word_i,
  input  logic                    in_fault_i,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [WORD_BITS-1:0]    out_value_o,
  output logic [STATUS_BITS-1:0]  out_status_o
);

  localparam int unsigned CntW      = $clog2(AttemptLimit + 1);
  localparam int unsigned FracShift = WORD_BITS - FRACTION_BITS;

  logic [WORD_BITS-1:0]    lower_q, lower_d, upper_q, upper_d, span_q;
  logic [MODE_BITS-1:0]    mode_q;
  logic                    bad_q, single_q;

  logic [WORD_BITS-1:0]    word_q, shift_q, rem_q;
  logic                    fault_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic [CntW-1:0]         rej_cnt_q, rej_cnt_d, rej_inc;

  logic                    out_valid_q;
  logic [WORD_BITS-1:0]    out_value_q, res_value;
  logic [STATUS_BITS-1:0]  out_status_q;
  status_e                 res_status;

  logic [WORD_BITS:0]      rem_sh, rem_sub, acc_sum;
  logic                    accept, alt_mode;

  // Configuration and derived range flags
  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    if (cfg_we_i && cfg_idx_i == CFG_LOWER) begin
      lower_d = cfg_data_i;
    end
    if (cfg_we_i && cfg_idx_i == CFG_UPPER) begin
      upper_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= '0;
      upper_q  <= '1;
      mode_q   <= MODE_RANGE;
      span_q   <= '0;
      bad_q    <= 1'b0;
      single_q <= 1'b0;
    end else if (cfg_we_i) begin
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      span_q   <= upper_d - lower_d + WORD_BITS'(1);
      bad_q    <= lower_d > upper_d;
      single_q <= lower_d == upper_d;
      if (cfg_idx_i == CFG_MODE) begin
        mode_q <= cfg_data_i[MODE_BITS-1:0];
      end
    end
  end

  // Remainder unit: one dividend bit a beat
  assign rem_sh  = {rem_q, shift_q[WORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q    <= in_word_i;
      shift_q   <= in_word_i;
      fault_q   <= in_fault_i;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.step) begin
      shift_q   <= shift_q << 1;
      rem_q     <= rem_sub[WORD_BITS] ? rem_sh[WORD_BITS-1:0] : rem_sub[WORD_BITS-1:0];
      div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
    end
  end

  // Accept when the draw lies in a whole block of span values
  assign acc_sum  = {1'b0, word_q} - {1'b0, rem_q} + {1'b0, span_q};
  assign accept   = !(acc_sum[WORD_BITS] && (|acc_sum[WORD_BITS-1:0]));
  assign alt_mode = (mode_q == MODE_BOOL) || (mode_q == MODE_FRAC);
  assign rej_inc  = rej_cnt_q + CntW'(1);

  always_comb begin
    res_value  = '0;
    res_status = ST_OK;
    rej_cnt_d  = '0;
    case (mode_q)
      MODE_BOOL: begin
        if (fault_q) begin
          res_status = ST_FAULT;
        end else begin
          res_value = {{(WORD_BITS-1){1'b0}}, word_q[0]};
        end
      end
      MODE_FRAC: begin
        if (fault_q) begin
          res_status = ST_FAULT;
        end else begin
          res_value = word_q >> FracShift;
        end
      end
      default: begin
        if (bad_q) begin
          res_status = ST_BAD_RANGE;
        end else if (single_q) begin
          res_value = lower_q;
        end else if (fault_q) begin
          res_status = ST_FAULT;
        end else if (span_q == '0) begin
          res_value = word_q;
        end else if (accept) begin
          res_value = lower_q + rem_q;
        end else if (rej_inc >= CntW'(AttemptLimit)) begin
          res_status = ST_TIMEOUT;
        end else begin
          res_status = ST_REJECT;
          rej_cnt_d  = rej_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        rej_cnt_q   <= rej_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign status_o.needs_div = !alt_mode && !bad_q && !single_q && !fault_q && (span_q != '0);
  assign status_o.div_last  = div_cnt_q == DIV_CNT_BITS'(WORD_BITS - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

// ----- hw/rtl/unbiased_random_range_mapper.sv -----
// Flow: each input beat is loaded, checked, passed through the 32-step remainder unit when a
// bounded draw needs it, and written to the output register; one beat is handled at a time.
// The next input beat is taken while a finished result still waits at the output register.
// Reset: asynchronous, active low; bounds return to the full 32-bit range, mode to
// bounded, rejection count to zero, and no result is pending.
`timescale 1ns / 1ps

module unbiased_random_range_mapper
  import urrm_pkg::*;
#(
  parameter int unsigned AttemptLimit = ATTEMPT_LIMIT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [WORD_BITS-1:0]    s_axis_tdata,  // [31:0] raw_word
  input  logic                    s_axis_tuser,  // [0] source_fault
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [WORD_BITS-1:0]    m_axis_tdata,  // [31:0] value
  output logic [STATUS_BITS-1:0]  m_axis_tuser   // [2:0] status
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  urrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  urrm_dpath #(
    .AttemptLimit (AttemptLimit)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_word_i    (s_axis_tdata),
    .in_fault_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule
